@@ design/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/mspi_pkg.sv @@
package mspi_pkg;
    localparam int VelW = 16;
    localparam int CmdW = 10;
    localparam int StW = 25;
    localparam int AccW = 44;
    localparam int DigW = 4;
    localparam int CoefW = 18;
    localparam logic [CoefW-1:0] ZdNormal = 18'd62915;
    localparam logic [CoefW-1:0] ZdcNormal = 18'd2621;
    localparam logic [CoefW-1:0] ZdStop = 18'd39322;
    localparam logic [CoefW-1:0] ZdcStop = 18'd26214;
    localparam logic [CoefW-1:0] Slope = 18'd439;
    localparam logic signed [AccW-1:0] OutLimit = 44'sd12032000;
    localparam int StopWindow = 1700;
    localparam int PolThreshold = 1100;
    typedef logic signed [VelW-1:0] vel_t;
    typedef logic signed [CmdW-1:0] cmd_t;
endpackage

@@ design/mspi_if.sv @@
interface mspi_vel_if;
    logic valid;
    logic ready;
    mspi_pkg::vel_t velocity;
    modport source (output valid, velocity, input ready);
    modport sink (input valid, velocity, output ready);
endinterface

@@ design/mspi_cmd_if.sv @@
interface mspi_cmd_if;
    logic valid;
    logic ready;
    mspi_pkg::cmd_t speed_command;
    modport source (output valid, speed_command, input ready);
    modport sink (input valid, speed_command, output ready);
endinterface

@@ design/mspi_cfg_if.sv @@
interface mspi_cfg_if;
    logic valid;
    logic ready;
    mspi_pkg::vel_t velocity_ref;
    modport source (output valid, velocity_ref, input ready);
    modport sink (input valid, velocity_ref, output ready);
endinterface

@@ design/motor_speed_pi_loop.sv @@
// A word is taken only in S_IDLE; it then runs through S_FILT_A, S_FILT_B, S_COMBINE,
// S_MAP and S_DONE before the next word is taken. A 4-bit digit-serial
// multiplier forms the three 18-bit coefficient products, 5 digits each.
// Reset clears the PI state, gain mode, polarity latch and the reference.
// The result register lets the next word enter while a result waits.
`include "assert_macros.svh"
module motor_speed_pi_loop (
    input logic clk,
    input logic rst_n,
    mspi_cfg_if.sink cfg,
    mspi_vel_if.sink vel_in,
    mspi_cmd_if.source cmd_out
);
    import mspi_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_FILT_A, S_FILT_B, S_COMBINE, S_MAP, S_DONE} state_t;

    state_t state_reg;
    logic signed [VelW-1:0] ref_reg;
    logic signed [VelW-1:0] vel_reg;
    logic signed [StW-1:0] filt_reg, last_reg;
    logic stop_reg, pol_reg, win_reg;
    logic signed [AccW-1:0] acc_reg;
    logic [CoefW-1:0] coef_reg;
    logic [2:0] cnt_reg;
    logic signed [StW-1:0] mcand_reg;
    logic signed [AccW-1:0] sum_reg;
    cmd_t cmd_reg;
    logic cmd_valid_reg;

    logic signed [VelW:0] err;
    logic signed [StW+2:0] u1;
    logic signed [AccW-1:0] u2, tot, sat, mag;
    logic signed [StW+DigW:0] prod;
    logic signed [AccW-1:0] part;
    logic in_win, stop_next, pol_next, done_map, cmd_load;
    logic [AccW-1:0] y;

    assign cfg.ready = 1'b1;
    assign vel_in.ready = (state_reg == S_IDLE);
    assign cmd_out.valid = cmd_valid_reg;
    assign cmd_out.speed_command = cmd_reg;

    assign in_win = (vel_in.velocity > -VelW'(StopWindow)) &&
                    (vel_in.velocity < VelW'(StopWindow)) && (ref_reg == '0);
    always_comb
    begin
        stop_next = stop_reg;
        pol_next = pol_reg;
        if (ref_reg != '0)
        begin
            stop_next = 1'b0;
        end
        else if (in_win)
        begin
            stop_next = 1'b1;
            if (vel_in.velocity < -VelW'(PolThreshold))
                pol_next = 1'b1;
            if (vel_in.velocity > VelW'(PolThreshold))
                pol_next = 1'b0;
        end
    end

    // One 4-bit digit of the coefficient times the multiplicand per cycle.
    assign prod = signed'({1'b0, coef_reg[DigW-1:0]}) * mcand_reg;
    assign part = AccW'(prod) <<< (DigW * cnt_reg);

    assign err = (VelW+1)'(ref_reg) - (VelW+1)'(vel_reg);
    assign u1 = stop_reg ? (StW+3)'(err) * 27'sd768 : (StW+3)'(err) * 27'sd384;
    assign u2 = (acc_reg + 44'sd32768) >>> 16;
    always_comb
    begin
        tot = AccW'(u1) + u2;
        if (win_reg && ((!pol_reg && tot > 0) || (pol_reg && tot < 0)))
            tot = '0;
        sat = tot;
        if (tot > OutLimit)
            sat = OutLimit;
        if (tot < -OutLimit)
            sat = -OutLimit;
    end
    assign mag = sum_reg < 0 ? -sum_reg : sum_reg;
    assign y = (acc_reg + (stop_reg ? 44'sd0 : 44'sd503316480)) >>> 24;
    assign done_map = (cnt_reg == 3'd4);
    assign cmd_load = (state_reg == S_DONE) && (!cmd_valid_reg || cmd_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ref_reg <= '0;
            vel_reg <= '0;
            filt_reg <= '0;
            last_reg <= '0;
            stop_reg <= 1'b0;
            pol_reg <= 1'b0;
            win_reg <= 1'b0;
            acc_reg <= '0;
            coef_reg <= '0;
            mcand_reg <= '0;
            sum_reg <= '0;
            cmd_reg <= '0;
            cmd_valid_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
                ref_reg <= cfg.velocity_ref;
            if (cmd_load)
                cmd_valid_reg <= 1'b1;
            else if (cmd_out.ready)
                cmd_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (vel_in.valid)
                    begin
                        vel_reg <= vel_in.velocity;
                        win_reg <= in_win;
                        stop_reg <= stop_next;
                        pol_reg <= pol_next;
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        coef_reg <= stop_next ? ZdStop : ZdNormal;
                        mcand_reg <= filt_reg;
                        state_reg <= S_FILT_A;
                    end
                end
                S_FILT_A, S_FILT_B, S_MAP:
                begin
                    acc_reg <= acc_reg + part;
                    if (done_map)
                    begin
                        cnt_reg <= '0;
                        if (state_reg == S_FILT_A)
                        begin
                            coef_reg <= stop_reg ? ZdcStop : ZdcNormal;
                            mcand_reg <= last_reg;
                            state_reg <= S_FILT_B;
                        end
                        else if (state_reg == S_FILT_B)
                            state_reg <= S_COMBINE;
                        else
                            state_reg <= S_DONE;
                    end
                    else
                    begin
                        coef_reg <= coef_reg >> DigW;
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_COMBINE:
                begin
                    filt_reg <= (win_reg && ((!pol_reg && (AccW'(u1) + u2) > 0) ||
                                (pol_reg && (AccW'(u1) + u2) < 0))) ? '0 : StW'(u2);
                    last_reg <= StW'(sat);
                    sum_reg <= sat;
                    acc_reg <= '0;
                    coef_reg <= Slope;
                    mcand_reg <= StW'(sat < 0 ? -sat : sat);
                    state_reg <= S_MAP;
                end
                S_DONE:
                begin
                    if (cmd_load)
                    begin
                        cmd_reg <= (mag == 0) ? '0 :
                                   (sum_reg < 0 ? -CmdW'(y) : CmdW'(y));
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_idle_ready, clk, rst_n, state_reg != S_IDLE, !vel_in.ready)
    `ASSERT_NEXT(a_done_valid, clk, rst_n, cmd_load, cmd_valid_reg)
    `ASSERT_IMPL(a_last_bound, clk, rst_n, 1'b1, last_reg <= StW'(12032000) && last_reg >= -StW'(12032000))
endmodule
